/* rtl/ale_pkg.sv */
// Shared types and constants for the array list engine.
package ale_pkg;
	localparam int CAPACITY = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CMD_CREATE = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_ELEMENT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_SEARCH = 3'd4,
		CMD_DISPLAY = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_NO_BATCH = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t cmd;
		logic signed [31:0] value;
		logic [7:0] batch_count;
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_REPLY
	} state_t;
endpackage

/* rtl/array_list_engine.sv */
// Top level of the array list engine.
//  channel | handshake            | payload
//  in      | valid / ready        | command, value, batch_count
//  out     | out_valid/out_ready  | status, position, item_value, removed_count, last
// Create, insert and element complete from idle. Delete, search and
// display walk the list, reading then checking each entry (S_READ, S_CHECK);
// a stalled receiver can hold the walk and the final reply.
// A new command starts only once the previous result has been taken.
// Reset clears count, open batch and queue; list contents stay undefined.
// A two-entry command queue lets input keep flowing while the back end
// is stalled on a result not yet taken.
module array_list_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	input  logic [2:0] command,
	input  logic signed [31:0] value,
	input  logic [7:0] batch_count,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [4:0] position,
	output logic signed [31:0] item_value,
	output logic [5:0] removed_count,
	output logic last
);
	logic q_valid, q_pop;
	ale_pkg::op_t q_op;

	ale_front u_front (.clk, .arst_n, .valid, .ready, .command, .value,
		.batch_count, .q_valid, .q_op, .q_pop);

	ale_back u_back (.clk, .arst_n, .q_valid, .q_op, .q_pop, .out_valid,
		.out_ready, .status, .position, .item_value, .removed_count, .last);
endmodule

/* rtl/ale_front.sv */
// Front end: accepts commands, drops unused codes, queues the rest.
module ale_front (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	input  logic [2:0] command,
	input  logic signed [31:0] value,
	input  logic [7:0] batch_count,
	output logic q_valid,
	output ale_pkg::op_t q_op,
	input  logic q_pop
);
	ale_pkg::op_t mem_q [ale_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, legal;

	assign ready = (cnt_q != 2'd2);
	assign legal = (command <= 3'd5);
	assign push = valid && ready && legal;
	assign q_valid = (cnt_q != 2'd0);
	assign q_op = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{cmd: ale_pkg::cmd_t'(command), value: value,
				batch_count: batch_count};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

/* rtl/ale_back.sv */
// Back end: list store and command sequencer with output register.
module ale_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  ale_pkg::op_t q_op,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [4:0] position,
	output logic signed [31:0] item_value,
	output logic [5:0] removed_count,
	output logic last
);
	logic [31:0] store_q [ale_pkg::CAPACITY];
	logic [31:0] rd_q;
	ale_pkg::state_t state_q, state_d;
	logic [ale_pkg::CNT_W-1:0] count_q, batch_q, ri_q, wi_q;
	logic [ale_pkg::CNT_W-1:0] count_d, batch_d, ri_d, wi_d;
	logic found_q, found_d;
	logic ov_q, ld;
	logic [2:0] st_d;
	logic [4:0] pos_d;
	logic [31:0] val_d;
	logic [5:0] rem_d;
	logic last_d;
	logic we;
	logic [4:0] wa;
	logic [31:0] wd;
	logic [8:0] sum;
	logic match, hit, cap;
	logic [4:0] hpos_q;
	logic [31:0] hval_q;

	assign sum = {3'd0, count_q} + {1'b0, q_op.batch_count};
	assign match = (rd_q == q_op.value);
	assign hit = (q_op.cmd == ale_pkg::CMD_DISPLAY) || match;
	assign out_valid = ov_q;

	always_ff @(posedge clk) begin
		if (we) store_q[wa] <= wd;
		rd_q <= store_q[ri_d[4:0]];
	end

	// held hit: sent once the next hit or the end of the scan shows whether it is last
	always_ff @(posedge clk) begin
		if (cap) begin
			hpos_q <= ri_q[4:0];
			hval_q <= rd_q;
		end
	end

	always_comb begin
		state_d = state_q; count_d = count_q; batch_d = batch_q;
		ri_d = ri_q; wi_d = wi_q; found_d = found_q; cap = 1'b0;
		ld = 1'b0; st_d = ale_pkg::ST_OK; pos_d = '0; val_d = '0; rem_d = '0;
		last_d = 1'b1; q_pop = 1'b0; we = 1'b0; wa = wi_q[4:0]; wd = rd_q;
		case (state_q)
			ale_pkg::S_IDLE: begin
				if (q_valid && !ov_q) begin
					ri_d = '0; wi_d = '0; found_d = 1'b0;
					if (q_op.cmd != ale_pkg::CMD_ELEMENT) batch_d = '0;
					ld = 1'b1;
					case (q_op.cmd)
						ale_pkg::CMD_CREATE: begin
							q_pop = 1'b1;
							if (q_op.batch_count > 8'(ale_pkg::CAPACITY))
								st_d = ale_pkg::ST_OVERFLOW;
							else begin
								count_d = '0; batch_d = q_op.batch_count[5:0];
							end
						end
						ale_pkg::CMD_INSERT: begin
							q_pop = 1'b1;
							if (sum > 9'(ale_pkg::CAPACITY) ||
								count_q >= 6'(ale_pkg::CAPACITY))
								st_d = ale_pkg::ST_OVERFLOW;
							else batch_d = q_op.batch_count[5:0];
						end
						ale_pkg::CMD_ELEMENT: begin
							q_pop = 1'b1;
							if (batch_q == '0 || count_q >= 6'(ale_pkg::CAPACITY)) begin
								batch_d = '0; st_d = ale_pkg::ST_NO_BATCH;
							end else begin
								we = 1'b1; wa = count_q[4:0]; wd = q_op.value;
								count_d = count_q + 6'd1; batch_d = batch_q - 6'd1;
							end
						end
						default: begin
							if (count_q == '0) begin
								q_pop = 1'b1; st_d = ale_pkg::ST_EMPTY;
							end else begin
								ld = 1'b0; state_d = ale_pkg::S_READ;
							end
						end
					endcase
				end
			end
			ale_pkg::S_READ: state_d = ale_pkg::S_CHECK;
			ale_pkg::S_CHECK: begin
				if (q_op.cmd != ale_pkg::CMD_DELETE && hit && found_q && ov_q) begin
					// held hit still waiting for the output slot
					state_d = ale_pkg::S_CHECK;
				end else begin
					ri_d = ri_q + 6'd1;
					state_d = (ri_d == count_q) ? ale_pkg::S_REPLY : ale_pkg::S_READ;
					if (q_op.cmd == ale_pkg::CMD_DELETE) begin
						if (!match) begin
							we = 1'b1; wi_d = wi_q + 6'd1;
						end
					end else if (hit) begin
						if (found_q) begin
							ld = 1'b1; pos_d = hpos_q; val_d = hval_q; last_d = 1'b0;
						end
						found_d = 1'b1; cap = 1'b1;
					end
				end
			end
			ale_pkg::S_REPLY: begin
				if (!ov_q) begin
					ld = 1'b1; q_pop = 1'b1; state_d = ale_pkg::S_IDLE;
					if (q_op.cmd == ale_pkg::CMD_DELETE) begin
						count_d = wi_q;
						if (wi_q == count_q) st_d = ale_pkg::ST_NOT_FOUND;
						else rem_d = count_q - wi_q;
					end else if (!found_q) st_d = ale_pkg::ST_NOT_FOUND;
					else begin
						// final hit closes the item
						pos_d = hpos_q; val_d = hval_q;
					end
				end
			end
			default: state_d = ale_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			status <= st_d; position <= pos_d; item_value <= val_d;
			removed_count <= rem_d; last <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ale_pkg::S_IDLE; count_q <= '0; batch_q <= '0;
			ri_q <= '0; wi_q <= '0; found_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			state_q <= state_d; count_q <= count_d; batch_q <= batch_d;
			ri_q <= ri_d; wi_q <= wi_d; found_q <= found_d;
			if (ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 6'(ale_pkg::CAPACITY)) else $error("count over capacity");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_ld: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> (!ov_q || out_ready) || !ov_q) else $error("result overwritten");
	a_batch: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + batch_q) <= 7'(ale_pkg::CAPACITY) || batch_q == '0)
		else $error("batch exceeds capacity");
`endif
endmodule

/* test/array_list_engine_check.sv */
// Checker for the array list engine: watches both channels, predicts results, compares them.
module array_list_engine_check (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	input  logic ready,
	input  logic [2:0] command,
	input  logic signed [31:0] value,
	input  logic [7:0] batch_count,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [2:0] status,
	input  logic [4:0] position,
	input  logic signed [31:0] item_value,
	input  logic [5:0] removed_count,
	input  logic last,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] position;
		logic [31:0] item_value;
		logic [5:0] removed_count;
		logic last;
	} reply_t;

	logic [31:0] entries [ale_pkg::CAPACITY];
	int unsigned entry_count;
	int unsigned open_batch;
	reply_t replies_due [$];

	function automatic reply_t mk(logic [2:0] st, int p, logic [31:0] v, int rm, bit l);
		reply_t r;
		r.status = st;
		r.position = p[4:0];
		r.item_value = v;
		r.removed_count = rm[5:0];
		r.last = l;
		return r;
	endfunction

	task automatic model_list(logic [2:0] cmd, logic [31:0] v, logic [7:0] cnt);
		int unsigned w;
		int k;
		if (cmd > ale_pkg::CMD_DISPLAY)
			return;
		if (cmd != ale_pkg::CMD_ELEMENT)
			open_batch = 0;
		case (cmd)
			ale_pkg::CMD_CREATE: begin
				if (cnt > ale_pkg::CAPACITY) begin
					replies_due.push_back(mk(ale_pkg::ST_OVERFLOW, 0, 0, 0, 1));
				end else begin
					entry_count = 0;
					open_batch = cnt;
					replies_due.push_back(mk(ale_pkg::ST_OK, 0, 0, 0, 1));
				end
			end
			ale_pkg::CMD_INSERT: begin
				if (entry_count + cnt > ale_pkg::CAPACITY ||
					entry_count >= ale_pkg::CAPACITY) begin
					replies_due.push_back(mk(ale_pkg::ST_OVERFLOW, 0, 0, 0, 1));
				end else begin
					open_batch = cnt;
					replies_due.push_back(mk(ale_pkg::ST_OK, 0, 0, 0, 1));
				end
			end
			ale_pkg::CMD_ELEMENT: begin
				if (open_batch == 0 || entry_count >= ale_pkg::CAPACITY) begin
					open_batch = 0;
					replies_due.push_back(mk(ale_pkg::ST_NO_BATCH, 0, 0, 0, 1));
				end else begin
					entries[entry_count] = v;
					entry_count++;
					open_batch--;
					replies_due.push_back(mk(ale_pkg::ST_OK, 0, 0, 0, 1));
				end
			end
			ale_pkg::CMD_DELETE: begin
				if (entry_count == 0) begin
					replies_due.push_back(mk(ale_pkg::ST_EMPTY, 0, 0, 0, 1));
				end else begin
					w = 0;
					for (int i = 0; i < entry_count; i++)
						if (entries[i] != v) begin
							entries[w] = entries[i];
							w++;
						end
					if (w == entry_count)
						replies_due.push_back(mk(ale_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
					else
						replies_due.push_back(mk(ale_pkg::ST_OK, 0, 0, entry_count - w, 1));
					entry_count = w;
				end
			end
			default: begin
				if (entry_count == 0) begin
					replies_due.push_back(mk(ale_pkg::ST_EMPTY, 0, 0, 0, 1));
				end else begin
					k = 0;
					for (int i = 0; i < entry_count; i++)
						if (cmd == ale_pkg::CMD_DISPLAY || entries[i] == v) begin
							replies_due.push_back(mk(ale_pkg::ST_OK, i, entries[i], 0, 0));
							k++;
						end
					if (k == 0)
						replies_due.push_back(mk(ale_pkg::ST_NOT_FOUND, 0, 0, 0, 1));
					else
						replies_due[$].last = 1;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t e;
		if (!arst_n) begin
			entry_count = 0;
			open_batch = 0;
			fail_count = 0;
			replies_due.delete();
		end else begin
			if (valid && ready)
				model_list(command, value, batch_count);
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count = fail_count + 1;
				end else begin
					e = replies_due.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d actual %0d", e.status, status);
						fail_count = fail_count + 1;
					end
					if (position !== e.position) begin
						$error("position: expected %0d actual %0d", e.position, position);
						fail_count = fail_count + 1;
					end
					if (item_value !== e.item_value) begin
						$error("item_value: expected %0d actual %0d",
							$signed(e.item_value), item_value);
						fail_count = fail_count + 1;
					end
					if (removed_count !== e.removed_count) begin
						$error("removed_count: expected %0d actual %0d",
							e.removed_count, removed_count);
						fail_count = fail_count + 1;
					end
					if (last !== e.last) begin
						$error("last: expected %0d actual %0d", e.last, last);
						fail_count = fail_count + 1;
					end
				end
			end
		end
		pending = replies_due.size();
	end
endmodule

/* test/array_list_engine_test.sv */
// Top of the array list engine testbench: clock, reset, stimulus and verdict.
module array_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic ready;
	logic [2:0] command = '0;
	logic signed [31:0] value = '0;
	logic [7:0] batch_count = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [4:0] position;
	logic signed [31:0] item_value;
	logic [5:0] removed_count;
	logic last;
	int fail_count;
	int pending;
	bit stim_done = 0;

	array_list_engine dut (.*);
	array_list_engine_check checker_i (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Small pool of values so searches and deletes actually hit; the rest random.
	logic signed [31:0] val_pool [4] = '{32'sd7, -32'sd1, 32'sh7fffffff, 32'sh80000000};
	int burst_left = 0;

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) != 0)
			return val_pool[$urandom_range(0, 3)];
		return $urandom();
	endfunction

	// One transfer on the input channel. Gaps come between bursts.
	task automatic send_op(logic [2:0] cmd, logic [31:0] v, logic [7:0] cnt);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap != 0) begin
				valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		command <= cmd;
		value <= v;
		batch_count <= cnt;
		valid <= 1;
		do @(posedge clk); while (!ready);
		@(negedge clk);
	endtask

	// A well-formed batch: open it, then fill it (sometimes short, to abandon it).
	task automatic send_batch(logic [2:0] opener, int n);
		int fill;
		send_op(opener, $urandom(), n[7:0]);
		fill = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
		for (int i = 0; i < fill; i++)
			send_op(ale_pkg::CMD_ELEMENT, pick_value(), 8'($urandom()));
	endtask

	// Receiver stalls on its own pattern: runs of ready and runs of stall.
	initial begin
		int run;
		forever begin
			run = $urandom_range(1, 10);
			out_ready <= ($urandom_range(0, 3) != 0);
			repeat (run) @(negedge clk);
		end
	end

	initial begin
		int r;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: empty list cases, element without batch, oversize create, unused codes, then a short list.
		send_op(ale_pkg::CMD_DELETE, '0, 8'd0);
		send_op(ale_pkg::CMD_SEARCH, '0, 8'd0);
		send_op(ale_pkg::CMD_DISPLAY, '0, 8'd0);
		send_op(ale_pkg::CMD_ELEMENT, 32'h80000000, 8'hff);
		send_op(ale_pkg::CMD_CREATE, '0, 8'd33);
		send_op(ale_pkg::CMD_CREATE, '0, 8'd255);
		send_op(3'd6, '0, 8'd0);
		send_op(3'd7, 32'hffffffff, 8'hff);
		send_op(ale_pkg::CMD_CREATE, '0, 8'd3);
		send_op(ale_pkg::CMD_ELEMENT, 32'h7fffffff, 8'd0);
		send_op(ale_pkg::CMD_ELEMENT, 32'h80000000, 8'd0);
		send_op(ale_pkg::CMD_ELEMENT, 32'h7fffffff, 8'd0);
		send_op(ale_pkg::CMD_ELEMENT, 32'd5, 8'd0);
		send_op(ale_pkg::CMD_SEARCH, 32'h7fffffff, 8'd0);
		send_op(ale_pkg::CMD_SEARCH, 32'd1, 8'd0);
		send_op(ale_pkg::CMD_DELETE, 32'd1, 8'd0);
		send_op(ale_pkg::CMD_DELETE, 32'h7fffffff, 8'd0);
		send_op(ale_pkg::CMD_DISPLAY, '0, 8'd0);
		send_op(ale_pkg::CMD_INSERT, '0, 8'd32);
		send_op(ale_pkg::CMD_INSERT, '0, 8'd31);
		send_op(ale_pkg::CMD_ELEMENT, 32'd1, 8'd0);
		send_op(ale_pkg::CMD_SEARCH, 32'd1, 8'd0);
		// Random: mostly batches with random content, some noise.
		for (int n = 0; n < 60; n++) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				send_batch(ale_pkg::CMD_CREATE,
					($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 8));
			else if (r < 5)
				send_batch(ale_pkg::CMD_INSERT, $urandom_range(0, 6));
			else if (r == 5)
				send_op(ale_pkg::CMD_DELETE, pick_value(), 8'($urandom()));
			else if (r == 6)
				send_op(ale_pkg::CMD_SEARCH, pick_value(), 8'($urandom()));
			else if (r == 7)
				send_op(ale_pkg::CMD_DISPLAY, $urandom(), 8'($urandom()));
			else
				send_op(3'($urandom_range(0, 7)), $urandom(), 8'($urandom()));
		end
		valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule

/* array_list_engine.f */
rtl/ale_pkg.sv
rtl/ale_front.sv
rtl/ale_back.sv
rtl/array_list_engine.sv
test/array_list_engine_check.sv
test/array_list_engine_test.sv
